### hw/rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
package bpfa_pkg;
    localparam int NUM_PAGES_DEF = 32768;
    localparam logic [12:0] BYTES_RESET = 13'd4096;
    localparam logic [1:0] ADDR_BITMAP_BYTES = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE = 2'd1;
    localparam logic [1:0] FUNC_MARK = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
endpackage

### hw/rtl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// Bitmap page allocator with a next-fit pointer; the bitmap lives in one
// synchronous RAM of NUM_PAGES/8 bytes, one byte read and one written per cycle.
// After reset a clearing pass sets every byte to all used; no item is
// accepted during it. Free and mark read and then write back each byte that
// the range touches, in turn. Allocate scans page by page from the pointer,
// then writes the run back byte by byte, so its cost grows with the
// distance to a fitting free run plus its length.
module bitmap_page_frame_allocator #(
    parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [14:0] s_start_page,
    input  logic [15:0] s_page_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [14:0] m_first_page
);
    localparam int NBYTES = NUM_PAGES / 8;
    localparam int AW = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int PW = ($clog2(NUM_PAGES) + 1 > 17) ? $clog2(NUM_PAGES) + 1 : 17;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_SCAN, S_WRD, S_WMOD, S_DONE} state_t;

    state_t            state_reg;
    logic [7:0]        mem [NBYTES];
    logic [7:0]        rdata_reg;
    logic [AW:0]       clr_reg;
    logic [12:0]       bytes_reg;
    logic [PW-1:0]     ptr_reg, pos_reg, run_reg, wpos_reg, wend_reg;
    logic [16:0]       match_reg;
    logic [15:0]       cnt_reg;
    logic              set_reg;
    logic [1:0]        status_reg;
    logic [14:0]       first_reg;
    logic              mv_reg;

    logic [PW-1:0]     limit;
    logic [AW-1:0]     raddr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata, wmask;
    logic [PW-1:0]     wbyte_end;
    logic              page_bit;

    always_comb begin
        if (32'(bytes_reg) > 32'(NBYTES)) limit = PW'(NUM_PAGES);
        else limit = PW'({bytes_reg, 3'b000});
    end

    assign raddr = (state_reg == S_WRD || state_reg == S_WMOD) ? wpos_reg[AW+2:3]
                                                               : pos_reg[AW+2:3];
    assign page_bit = rdata_reg[3'd7 - pos_reg[2:0]];
    assign wbyte_end = {wpos_reg[PW-1:3], 3'b000} + PW'(8);

    always_comb begin
        wmask = '0;
        for (int i = 0; i < 8; i++) begin
            if ((({wpos_reg[PW-1:3], 3'b000} + PW'(i)) >= wpos_reg) &&
                (({wpos_reg[PW-1:3], 3'b000} + PW'(i)) < wend_reg))
                wmask[7-i] = 1'b1;
        end
        wdata = set_reg ? (rdata_reg | wmask) : (rdata_reg & ~wmask);
    end

    always_comb begin
        we = 1'b0;
        waddr = wpos_reg[AW+2:3];
        if (state_reg == S_CLEAR) begin
            we = 1'b1;
            waddr = clr_reg[AW-1:0];
        end else if (state_reg == S_WMOD) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
        if (we) mem[waddr] <= (state_reg == S_CLEAR) ? 8'hff : wdata;
    end

    assign pready = 1'b1;
    assign prdata = {19'd0, bytes_reg};
    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_status = status_reg;
    assign m_first_page = first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            bytes_reg <= bpfa_pkg::BYTES_RESET;
            ptr_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == bpfa_pkg::ADDR_BITMAP_BYTES)
                bytes_reg <= pwdata[12:0];
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(NBYTES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        first_reg <= '0;
                        cnt_reg <= s_page_count;
                        wpos_reg <= PW'(s_start_page);
                        if (32'(s_start_page) + 32'(s_page_count) > 32'(NUM_PAGES))
                            wend_reg <= PW'(NUM_PAGES);
                        else
                            wend_reg <= PW'(32'(s_start_page) + 32'(s_page_count));
                        case (s_func)
                            bpfa_pkg::FUNC_ALLOC: begin
                                if (s_page_count == '0) begin
                                    status_reg <= bpfa_pkg::ST_INVALID;
                                    state_reg <= S_DONE;
                                end else begin
                                    status_reg <= bpfa_pkg::ST_OK;
                                    set_reg <= 1'b1;
                                    pos_reg <= ptr_reg;
                                    run_reg <= ptr_reg;
                                    match_reg <= '0;
                                    state_reg <= S_RD;
                                end
                            end
                            bpfa_pkg::FUNC_FREE: begin
                                status_reg <= bpfa_pkg::ST_OK;
                                if (PW'(s_start_page) < ptr_reg) ptr_reg <= PW'(s_start_page);
                                set_reg <= 1'b0;
                                state_reg <= S_WRD;
                            end
                            bpfa_pkg::FUNC_MARK: begin
                                status_reg <= bpfa_pkg::ST_OK;
                                set_reg <= 1'b1;
                                state_reg <= S_WRD;
                            end
                            default: begin
                                status_reg <= bpfa_pkg::ST_INVALID;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (match_reg == 17'(cnt_reg)) begin
                        ptr_reg <= pos_reg;
                        first_reg <= 15'(run_reg);
                        wpos_reg <= run_reg;
                        wend_reg <= pos_reg;
                        state_reg <= S_WRD;
                    end else if (pos_reg >= limit) begin
                        status_reg <= bpfa_pkg::ST_NOMEM;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!page_bit) begin
                        match_reg <= match_reg + 1'b1;
                    end else begin
                        match_reg <= '0;
                        run_reg <= pos_reg + 1'b1;
                    end
                    pos_reg <= pos_reg + 1'b1;
                    state_reg <= S_RD;
                end
                S_WRD: begin
                    if (wpos_reg >= wend_reg) state_reg <= S_DONE;
                    else state_reg <= S_WMOD;
                end
                S_WMOD: begin
                    wpos_reg <= wbyte_end;
                    state_reg <= S_WRD;
                end
                S_DONE: begin
                    mv_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
